@@ design/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int DEPTH  = 8;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int FILL_W = 4;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] item;
        logic signed [DATA_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic signed [DATA_W-1:0] item;
        logic signed [DATA_W-1:0] prio;
    } t_ctl;

endpackage

@@ design/spq_if.sv @@
// Handshake interfaces for the request and result channels.
interface spq_in_if;
    import spq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] priority_req;

    modport source (output valid, cmd, item_value, priority_req, input ready);
    modport sink   (input valid, cmd, item_value, priority_req, output ready);
endinterface

interface spq_out_if;
    import spq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] out_item;
    logic signed [DATA_W-1:0] out_priority;
    logic [FILL_W-1:0]        fill_count;

    modport source (output valid, status, out_item, out_priority, fill_count, input ready);
    modport sink   (input valid, status, out_item, out_priority, fill_count, output ready);
endinterface

@@ design/spq_cell.sv @@
// One slot of the sorted shift chain: hold, shift in from a neighbor, or load the new entry.
module spq_cell
    import spq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_ctl   i_ctl,
    input  t_entry i_prev,
    input  logic   i_prev_take,
    input  t_entry i_next,
    output t_entry o_entry,
    output logic   o_take
);

    t_entry r_entry;
    t_entry n_entry;

    // Take part in the insert when empty or holding a strictly larger priority.
    assign o_take = !r_entry.valid || (r_entry.prio > i_ctl.prio);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.deq) begin
            n_entry = i_next;
        end else if (i_ctl.enq && o_take) begin
            if (i_prev_take) begin
                n_entry = i_prev;
            end else begin
                n_entry.valid = 1'b1;
                n_entry.item  = i_ctl.item;
                n_entry.prio  = i_ctl.prio;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry.item <= n_entry.item;
        r_entry.prio <= n_entry.prio;
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
    end

    assign o_entry = r_entry;

endmodule

@@ design/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: cell chain, entry count and result register.
//
// Usage:
//   i_in carries one request per beat: cmd (enqueue or dequeue), item_value
//   and priority_req. o_out returns exactly one result beat per request:
//   status (ok, overflow, empty), out_item, out_priority and fill_count.
//   Entries sit in a chain of DEPTH cells kept sorted by priority, lowest at
//   cell 0. An enqueue compares the new priority in every cell at once; the
//   cells at and behind the insert point shift back one place and the new
//   entry lands after every entry whose priority is not greater, so equal
//   priorities leave in arrival order. A dequeue shifts the whole chain
//   forward one place and returns what cell 0 held.
//   The result is registered and appears in the cycle after the request beat.
//   Throughput: one request per cycle while the receiver keeps taking results.
//   A full queue rejects an enqueue with overflow; an empty queue answers a
//   dequeue with empty; the queue is left unchanged in both cases.
//   Reset clears all cell valid bits and the count; no result is pending.
//   When the receiver stalls, the result register holds its beat and the
//   request channel drops ready until that beat is taken.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_in_if.sink     i_in,
    spq_out_if.source  o_out
);

    // Chain wiring: one extra slot, at index DEPTH, serves both boundary neighbors.
    t_entry             w_entry [DEPTH+1];
    logic               w_take  [DEPTH+1];
    t_ctl               w_ctl;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    logic               r_out_valid;
    logic [1:0]         r_status;
    logic signed [DATA_W-1:0] r_item;
    logic signed [DATA_W-1:0] r_prio;
    logic [FILL_W-1:0]  r_fill;

    logic [1:0]         n_status;
    logic signed [DATA_W-1:0] n_item;
    logic signed [DATA_W-1:0] n_prio;

    // Accept a new request whenever the result slot is free or being drained.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    always_comb begin
        w_ctl.enq  = w_accept && (i_in.cmd == CMD_ENQ) && !w_full;
        w_ctl.deq  = w_accept && (i_in.cmd == CMD_DEQ) && !w_empty;
        w_ctl.item = i_in.item_value;
        w_ctl.prio = i_in.priority_req;
    end

    // The far end of the chain feeds an empty slot on dequeue.
    assign w_entry[DEPTH] = '0;

    // Cell 0 has no predecessor, so it always loads the new entry when it takes.
    assign w_take[DEPTH] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_entry w_prev;
            logic   w_prev_take;
            if (g == 0) begin : g_head
                assign w_prev      = '0;
                assign w_prev_take = w_take[DEPTH];
            end else begin : g_body
                assign w_prev      = w_entry[g-1];
                assign w_prev_take = w_take[g-1];
            end
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_prev      (w_prev),
                .i_prev_take (w_prev_take),
                .i_next      (w_entry[g+1]),
                .o_entry     (w_entry[g]),
                .o_take      (w_take[g])
            );
        end
    endgenerate

    // Count and result contents for the accepted request.
    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_item   = '0;
        n_prio   = '0;
        if (w_ctl.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.deq) begin
            n_count = r_count - CNT_W'(1);
            n_item  = w_entry[0].item;
            n_prio  = w_entry[0].prio;
        end else if (i_in.cmd == CMD_ENQ) begin
            n_status = ST_OVERFLOW;
        end else begin
            n_status = ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_item   <= n_item;
            r_prio   <= n_prio;
            r_fill   <= FILL_W'(n_count);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.out_item     = r_item;
    assign o_out.out_priority = r_prio;
    assign o_out.fill_count   = r_fill;

endmodule

@@ dv/sorted_priority_queue_test.sv @@
// Self-checking testbench for the sorted priority queue: random and directed requests.
module sorted_priority_queue_test;
    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no beat on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to hold after the last expected result, to catch stray beats.
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 1730;

    typedef struct {
        t_cmd                     cmd;
        logic signed [DATA_W-1:0] item;
        logic signed [DATA_W-1:0] prio;
    } t_queue_request;

    typedef struct {
        t_status                  status;
        logic signed [DATA_W-1:0] item;
        logic signed [DATA_W-1:0] prio;
        logic [FILL_W-1:0]        fill;
    } t_queue_reply;

    typedef struct {
        logic signed [DATA_W-1:0] item;
        logic signed [DATA_W-1:0] prio;
    } t_stored_entry;

    logic clk;
    logic rst_n;

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    sorted_priority_queue uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_queue_request pending_requests[$];
    t_queue_reply   predicted_replies[$];
    // Shadow of the queue contents, front first, always kept in priority order.
    t_stored_entry  shadow_entries[$];

    int   total_items;
    int   sent_count;
    int   idle_cycles;
    int   error_count;
    logic in_took;

    // Apply one accepted request to the shadow queue and return the reply it must cause.
    function automatic t_queue_reply model_queue_op(t_queue_request r);
        t_queue_reply  rep;
        t_stored_entry e;
        int            pos;
        rep.status = ST_OK;
        rep.item   = '0;
        rep.prio   = '0;
        if (r.cmd == CMD_ENQ) begin
            if (shadow_entries.size() >= DEPTH) begin
                rep.status = ST_OVERFLOW;
            end else begin
                // Walk back past every entry with a strictly greater priority,
                // so ties keep arrival order.
                pos = shadow_entries.size();
                while (pos > 0 && shadow_entries[pos-1].prio > r.prio)
                    pos--;
                e.item = r.item;
                e.prio = r.prio;
                shadow_entries.insert(pos, e);
            end
        end else begin
            if (shadow_entries.size() == 0) begin
                rep.status = ST_EMPTY;
            end else begin
                e        = shadow_entries.pop_front();
                rep.item = e.item;
                rep.prio = e.prio;
            end
        end
        rep.fill = FILL_W'(shadow_entries.size());
        return rep;
    endfunction

    function automatic t_queue_request make_request(t_cmd c, logic [DATA_W-1:0] item,
                                                    logic [DATA_W-1:0] prio);
        t_queue_request r;
        r.cmd  = c;
        r.item = item;
        r.prio = prio;
        return r;
    endfunction

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: change inputs on the falling edge, hold a beat until it is taken.
    always @(negedge clk) begin : drive_requests
        int             send_idle;
        int             recv_idle;
        t_queue_request r;
        // Idle mix per phase: sender light/receiver heavy, then swapped, then none.
        if (sent_count * 3 < total_items) begin
            send_idle = 21;
            recv_idle = 74;
        end else if (sent_count * 3 < total_items * 2) begin
            send_idle = 74;
            recv_idle = 21;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        if (!rst_n) begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            if (!in_ch.valid || in_took) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle) begin
                    r                  = pending_requests.pop_front();
                    in_ch.cmd          <= r.cmd;
                    in_ch.item_value   <= r.item;
                    in_ch.priority_req <= r.prio;
                    in_ch.valid        <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Monitor: sample both channels on the rising edge, predict and compare.
    always @(posedge clk) begin : watch_channels
        t_queue_request r;
        t_queue_reply   want;
        logic           in_fire;
        logic           out_fire;
        in_fire  = rst_n && in_ch.valid && in_ch.ready;
        out_fire = rst_n && out_ch.valid && out_ch.ready;
        in_took <= in_fire;
        if (in_fire) begin
            r.cmd  = t_cmd'(in_ch.cmd);
            r.item = in_ch.item_value;
            r.prio = in_ch.priority_req;
            predicted_replies.push_back(model_queue_op(r));
            sent_count <= sent_count + 1;
        end
        if (out_fire) begin
            if (predicted_replies.size() == 0) begin
                $display("%0t: unexpected result beat status=%0d item=%0d prio=%0d fill=%0d",
                         $time, out_ch.status, out_ch.out_item, out_ch.out_priority,
                         out_ch.fill_count);
                error_count = error_count + 1;
            end else begin
                want = predicted_replies.pop_front();
                if (out_ch.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_ch.status);
                    error_count = error_count + 1;
                end
                if (out_ch.out_item !== want.item) begin
                    $display("%0t: out_item expected %0d actual %0d",
                             $time, want.item, out_ch.out_item);
                    error_count = error_count + 1;
                end
                if (out_ch.out_priority !== want.prio) begin
                    $display("%0t: out_priority expected %0d actual %0d",
                             $time, want.prio, out_ch.out_priority);
                    error_count = error_count + 1;
                end
                if (out_ch.fill_count !== want.fill) begin
                    $display("%0t: fill_count expected %0d actual %0d",
                             $time, want.fill, out_ch.fill_count);
                    error_count = error_count + 1;
                end
            end
        end
        if (in_fire || out_fire || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : run_test
        t_queue_request r;
        int             burst_left;
        int             enq_pct;
        int             mode;
        logic [DATA_W-1:0] p;

        // Drive every input to a known value before the first edge.
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.cmd          = CMD_ENQ;
        in_ch.item_value   = '0;
        in_ch.priority_req = '0;
        out_ch.ready       = 1'b0;
        in_took            = 1'b0;
        sent_count         = 0;
        idle_cycles        = 0;
        error_count        = 0;
        burst_left         = 0;
        enq_pct            = 50;

        // Directed: dequeue on empty, then fill with extreme and tied priorities.
        pending_requests.push_back(make_request(CMD_DEQ, 32'hDEAD_BEEF, 32'h1234_5678));
        pending_requests.push_back(make_request(CMD_ENQ, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_requests.push_back(make_request(CMD_ENQ, 32'h8000_0000, 32'h8000_0000));
        pending_requests.push_back(make_request(CMD_ENQ, 32'h0000_0000, 32'h0000_0000));
        pending_requests.push_back(make_request(CMD_ENQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // Ties with an existing priority must leave in arrival order.
        pending_requests.push_back(make_request(CMD_ENQ, 32'd1, 32'hFFFF_FFFF));
        pending_requests.push_back(make_request(CMD_ENQ, 32'd2, 32'hFFFF_FFFF));
        pending_requests.push_back(make_request(CMD_ENQ, 32'd5, 32'h7FFF_FFFF));
        pending_requests.push_back(make_request(CMD_ENQ, 32'd6, 32'h8000_0000));
        // Full: these enqueues must overflow and leave the queue as it is.
        pending_requests.push_back(make_request(CMD_ENQ, 32'hAAAA_AAAA, 32'h8000_0000));
        pending_requests.push_back(make_request(CMD_ENQ, 32'h5555_5555, 32'h5555_5555));
        // Drain completely, including the last entry, then dequeue on empty again.
        repeat (DEPTH) pending_requests.push_back(make_request(CMD_DEQ, $urandom, $urandom));
        pending_requests.push_back(make_request(CMD_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // Refill after the head returned to zero.
        pending_requests.push_back(make_request(CMD_ENQ, 32'd7, 32'd3));
        pending_requests.push_back(make_request(CMD_DEQ, 32'd0, 32'd0));

        // Random: bursts that lean toward filling, draining or staying balanced,
        // so the fill level sweeps between empty and full many times.
        repeat (RANDOM_ITEMS) begin
            if (burst_left == 0) begin
                mode       = $urandom_range(2);
                enq_pct    = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
                burst_left = $urandom_range(24, 4);
            end
            burst_left--;
            case ($urandom_range(3))
                0:       p = $urandom;
                1:       p = DATA_W'($signed($urandom_range(7)) - 4); // dense ties
                2:       p = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                default: p = $urandom;
            endcase
            r.cmd  = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            r.item = $urandom;
            r.prio = p;
            pending_requests.push_back(r);
        end
        total_items = pending_requests.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait until every request is in and every reply has been checked.
        while (sent_count < total_items || predicted_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
